@@ rtl/gtpb_pkg.sv @@
`default_nettype none

package gtpb_pkg;

   localparam int PixW   = 16;
   localparam int ChanW  = 5;
   localparam int GreenW = 6;
   localparam int GrayW  = 6;
   localparam int SumW   = 8;
   localparam int ProdW  = 17;
   localparam int AddrW  = 3;
   localparam int DataW  = 32;
   localparam int ModeW  = 8;

   localparam logic [PixW-1:0]   Key565 = 16'hF81F;
   localparam logic [PixW-1:0]   Key555 = 16'h7C1F;
   localparam logic [ChanW-1:0]  Max5   = 5'h1F;
   localparam logic [GreenW-1:0] Max6   = 6'h3F;

   // Three times the sum, divided by ten, as a multiply by 3 * 205 and a shift by 11.
   // The result is exact for every sum that the channels can give, up to 188.
   localparam logic [9:0] GrayMul   = 10'd615;
   localparam int         GrayShift = 11;

   typedef enum logic [0:0] {
      REG_FORMAT = 1'b0,
      REG_TINT   = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic             format_565;
      logic [ModeW-1:0] tint_mode;
   } cfg_type;

   typedef struct packed {
      logic             transp;
      logic [GrayW-1:0] gray;
      logic [PixW-1:0]  dst_pix;
   } gray_word_type;

endpackage

`default_nettype wire

@@ rtl/gtpb_csr.sv @@
`default_nettype none

module gtpb_csr (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [gtpb_pkg::AddrW-1:0] csr_paddr,
   input  wire logic [gtpb_pkg::DataW-1:0] csr_pwdata,
   output      logic [gtpb_pkg::DataW-1:0] csr_prdata,
   output      logic                      csr_pready,
   output      gtpb_pkg::cfg_type         cfg
);
   import gtpb_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type idx;
   logic          wr;

   assign idx = reg_index_type'(csr_paddr[2]);
   assign wr  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (idx)
            REG_FORMAT: cfg_in.format_565 = csr_pwdata[0];
            REG_TINT:   cfg_in.tint_mode  = csr_pwdata[ModeW-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.format_565 <= 1'b1;
         cfg_ff.tint_mode  <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_FORMAT: csr_prdata[0]       = cfg_ff.format_565;
         REG_TINT:   csr_prdata[ModeW-1:0] = cfg_ff.tint_mode;
         default:    csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/gtpb_gray.sv @@
`default_nettype none

module gtpb_gray (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_stall,
   input  wire logic [gtpb_pkg::PixW-1:0] src_pix,
   input  wire logic [gtpb_pkg::PixW-1:0] dst_pix,
   input  wire gtpb_pkg::cfg_type        cfg,
   output      logic                     out_valid,
   input  wire logic                     out_stall,
   output      gtpb_pkg::gray_word_type  out_word
);
   import gtpb_pkg::*;

   logic            s1_valid_ff, s1_valid_in;
   logic [PixW-1:0] src_ff, src_in;
   logic [PixW-1:0] dst_ff, dst_in;
   logic            s2_valid_ff, s2_valid_in;
   gray_word_type   word_ff, word_in;

   logic              s1_stall;
   logic              s2_open;
   logic [ChanW-1:0]  r5, b5;
   logic [GreenW-1:0] g6;
   logic [SumW-1:0]   sum;
   logic [ProdW-1:0]  prod;

   assign s2_open  = !s2_valid_ff || !out_stall;
   assign s1_stall = s1_valid_ff && !s2_open;
   assign in_stall = s1_stall;

   always_comb begin
      s1_valid_in = s1_stall ? s1_valid_ff : in_valid;
      src_in      = src_ff;
      dst_in      = dst_ff;
      if (in_valid && !s1_stall) begin
         src_in = src_pix;
         dst_in = dst_pix;
      end
   end

   always_comb begin
      b5 = src_ff[ChanW-1:0];
      if (cfg.format_565) begin
         r5 = src_ff[15:11];
         g6 = src_ff[10:5];
      end else begin
         r5 = src_ff[14:10];
         g6 = {1'b0, src_ff[9:5]};
      end
      sum  = SumW'(r5) + SumW'({g6, 1'b0}) + SumW'(b5);
      prod = ProdW'(sum) * ProdW'(GrayMul);
   end

   always_comb begin
      s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
      word_in     = word_ff;
      if (s1_valid_ff && s2_open) begin
         word_in.gray    = prod[GrayShift +: GrayW];
         word_in.dst_pix = dst_ff;
         word_in.transp  = cfg.format_565 ? (src_ff == Key565) : (src_ff == Key555);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff  <= src_in;
      dst_ff  <= dst_in;
      word_ff <= word_in;
   end

   assign out_valid = s2_valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

@@ rtl/gtpb_shade.sv @@
`default_nettype none

module gtpb_shade (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output      logic                     in_stall,
   input  wire gtpb_pkg::gray_word_type  in_word,
   input  wire gtpb_pkg::cfg_type        cfg,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      logic [gtpb_pkg::PixW-1:0] rsp_out_pix,
   output      logic                     rsp_write_en
);
   import gtpb_pkg::*;

   logic            valid_ff, valid_in;
   logic [PixW-1:0] pix_ff, pix_in;
   logic            we_ff, we_in;

   logic                    open;
   logic [ChanW-1:0]        dr, db;
   logic [GreenW-1:0]       dg;
   logic [ChanW+GrayW-1:0]  pr, pb;
   logic [GreenW+GrayW-1:0] pg;
   logic [GrayW-1:0]        tr, tb, tg5, tg6;
   logic [ChanW-1:0]        r, b, g5, c;
   logic [GreenW-1:0]       g6;
   logic [PixW-1:0]         res;

   assign open     = !valid_ff || !rsp_stall;
   assign in_stall = valid_ff && rsp_stall;

   always_comb begin
      db = in_word.dst_pix[ChanW-1:0];
      if (cfg.format_565) begin
         dr = in_word.dst_pix[15:11];
         dg = in_word.dst_pix[10:5];
      end else begin
         dr = in_word.dst_pix[14:10];
         dg = {1'b0, in_word.dst_pix[9:5]};
      end
      pr  = (ChanW+GrayW)'(dr) * (ChanW+GrayW)'(in_word.gray);
      pb  = (ChanW+GrayW)'(db) * (ChanW+GrayW)'(in_word.gray);
      pg  = (GreenW+GrayW)'(dg) * (GreenW+GrayW)'(in_word.gray);
      tr  = pr[ChanW +: GrayW];
      tb  = pb[ChanW +: GrayW];
      tg5 = pg[ChanW +: GrayW];
      tg6 = pg[GreenW +: GrayW];
      c   = (in_word.gray > GrayW'(Max5)) ? Max5 : in_word.gray[ChanW-1:0];

      if (cfg.tint_mode == '0) begin
         r  = (tr > GrayW'(Max5)) ? Max5 : tr[ChanW-1:0];
         b  = (tb > GrayW'(Max5)) ? Max5 : tb[ChanW-1:0];
         g5 = (tg5 > GrayW'(Max5)) ? Max5 : tg5[ChanW-1:0];
         g6 = tg6;
      end else begin
         r  = c;
         b  = c;
         g5 = c;
         g6 = {c, 1'b0};
      end

      if (cfg.format_565) begin
         res = {r, g6, b};
      end else begin
         res = {1'b0, r, g5, b};
      end
   end

   always_comb begin
      valid_in = open ? in_valid : valid_ff;
      pix_in   = pix_ff;
      we_in    = we_ff;
      if (in_valid && open) begin
         pix_in = in_word.transp ? in_word.dst_pix : res;
         we_in  = !in_word.transp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
      we_ff  <= we_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_pix  = pix_ff;
   assign rsp_write_en = we_ff;

endmodule

`default_nettype wire

@@ rtl/grayscale_tint_pixel_blend.sv @@
// Channel  Direction  Handshake                      Payload
// req      in         req_valid / req_stall          req_src_pix, req_dst_pix
// rsp      out        rsp_valid / rsp_stall          rsp_out_pix, rsp_write_en
// csr      in         csr_psel / csr_penable         csr_paddr, csr_pwdata, csr_prdata
//
// One word is taken every cycle while req_stall is low.
// Each word passes through the input register, the gray register and the result register.
// Reset clears the valid flags and sets format_565 to 1 and tint_mode to 0.
// A stall on rsp backs up through the stages; a stage with room still accepts.
`default_nettype none

module grayscale_tint_pixel_blend (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output      logic                      req_stall,
   input  wire logic [gtpb_pkg::PixW-1:0]  req_src_pix,
   input  wire logic [gtpb_pkg::PixW-1:0]  req_dst_pix,
   output      logic                      rsp_valid,
   input  wire logic                      rsp_stall,
   output      logic [gtpb_pkg::PixW-1:0]  rsp_out_pix,
   output      logic                      rsp_write_en,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [gtpb_pkg::AddrW-1:0] csr_paddr,
   input  wire logic [gtpb_pkg::DataW-1:0] csr_pwdata,
   output      logic [gtpb_pkg::DataW-1:0] csr_prdata,
   output      logic                      csr_pready
);
   import gtpb_pkg::*;

   cfg_type       cfg;
   logic          gray_valid;
   logic          gray_stall;
   gray_word_type gray_word;

   gtpb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   gtpb_gray u_gray (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .src_pix   (req_src_pix),
      .dst_pix   (req_dst_pix),
      .cfg       (cfg),
      .out_valid (gray_valid),
      .out_stall (gray_stall),
      .out_word  (gray_word)
   );

   gtpb_shade u_shade (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (gray_valid),
      .in_stall     (gray_stall),
      .in_word      (gray_word),
      .cfg          (cfg),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_pix  (rsp_out_pix),
      .rsp_write_en (rsp_write_en)
   );

endmodule

`default_nettype wire

@@ bench/tb_grayscale_tint_pixel_blend.sv @@
`timescale 1ns / 1ps

module tb_grayscale_tint_pixel_blend;
   import gtpb_pkg::*;

   localparam int QuietLimit = 2000;

   typedef struct {
      logic [PixW-1:0] out_pix;
      logic            write_en;
   } blend_word_type;

   class blend_ledger;
      bit              fmt565;
      bit [ModeW-1:0]  mode;
      blend_word_type  awaited_q[$];
      int              errors;

      function new();
         fmt565  = 1'b1;
         mode    = '0;
         errors  = 0;
      endfunction

      function void set_format(bit f);
         fmt565 = f;
      endfunction

      function void set_mode(bit [ModeW-1:0] m);
         mode = m;
      endfunction

      function int clip(int v, int lim);
         return (v > lim) ? lim : v;
      endfunction

      function blend_word_type blend(logic [PixW-1:0] s, logic [PixW-1:0] d);
         blend_word_type o;
         int r, g, b, gray;
         o.out_pix  = d;
         o.write_en = 1'b0;
         if (fmt565) begin
            if (s == Key565) return o;
            r = s[15:11];
            g = s[10:5];
            b = s[4:0];
            gray = ((r + 2 * g + b) * 3) / 10;
            if (mode == 0) begin
               r = d[15:11];
               g = d[10:5];
               b = d[4:0];
               r = clip((r * gray) >> 5, 31);
               g = clip((g * gray) >> 6, 63);
               b = clip((b * gray) >> 5, 31);
            end else begin
               r = clip(gray, 31);
               g = clip(2 * r, 63);
               b = r;
            end
            o.out_pix = {r[4:0], g[5:0], b[4:0]};
         end else begin
            if (s == Key555) return o;
            r = s[14:10];
            g = s[9:5];
            b = s[4:0];
            gray = ((r + 2 * g + b) * 3) / 10;
            if (mode == 0) begin
               r = d[14:10];
               g = d[9:5];
               b = d[4:0];
               r = clip((r * gray) >> 5, 31);
               g = clip((g * gray) >> 5, 31);
               b = clip((b * gray) >> 5, 31);
            end else begin
               r = clip(gray, 31);
               g = r;
               b = r;
            end
            o.out_pix = {1'b0, r[4:0], g[4:0], b[4:0]};
         end
         o.write_en = 1'b1;
         return o;
      endfunction

      function void note_pair(logic [PixW-1:0] s, logic [PixW-1:0] d);
         awaited_q.push_back(blend(s, d));
      endfunction

      function void report(string field, int want, int got);
         errors++;
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
      endfunction

      function void check_pixel(logic [PixW-1:0] px, logic we);
         blend_word_type e;
         if (awaited_q.size() == 0) begin
            errors++;
            $error("result word 0x%04h with no word awaited", px);
            return;
         end
         e = awaited_q.pop_front();
         if (px !== e.out_pix) report("out_pix", e.out_pix, px);
         if (we !== e.write_en) report("write_en", e.write_en, we);
      endfunction

      function int pending();
         return awaited_q.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [PixW-1:0]   req_src_pix = '0;
   logic [PixW-1:0]   req_dst_pix = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PixW-1:0]   rsp_out_pix;
   logic              rsp_write_en;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [AddrW-1:0]  csr_paddr = '0;
   logic [DataW-1:0]  csr_pwdata = '0;
   logic [DataW-1:0]  csr_prdata;
   logic              csr_pready;

   blend_ledger ledger;
   int          gap_pct = 0;
   int          hold_pct = 0;
   int          quiet = 0;

   grayscale_tint_pixel_blend uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_src_pix  (req_src_pix),
      .req_dst_pix  (req_dst_pix),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_pix  (rsp_out_pix),
      .rsp_write_en (rsp_write_en),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) ledger.note_pair(req_src_pix, req_dst_pix);
         if (rsp_valid && !rsp_stall) ledger.check_pixel(rsp_out_pix, rsp_write_en);
      end
      rsp_stall <= ($urandom_range(99) < hold_pct);
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet <= 0;
      end else if (quiet >= QuietLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_pixel(input logic [PixW-1:0] s, input logic [PixW-1:0] d);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_src_pix <= s;
      req_dst_pix <= d;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [DataW-1:0] val);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_FORMAT: ledger.set_format(val[0]);
         REG_TINT:   ledger.set_mode(val[ModeW-1:0]);
      endcase
   endtask

   initial begin
      int seg;
      int pick;
      logic [PixW-1:0] s;
      logic [PixW-1:0] d;
      ledger = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (seg = 0; seg < 6; seg++) begin
         // Upper register bits are set in some writes; only the low bits must stick.
         case (seg)
            1: write_reg(REG_FORMAT, 32'hFFFF_FFFE);
            2: write_reg(REG_TINT, 32'h0000_01FF);
            3: write_reg(REG_FORMAT, 32'h0000_0001);
            4: begin
               write_reg(REG_FORMAT, 32'h0000_0000);
               write_reg(REG_TINT, 32'h0000_0100);
            end
            5: begin
               write_reg(REG_FORMAT, 32'hFFFF_FFFF);
               write_reg(REG_TINT, $urandom_range(1, 255));
            end
            default: ;
         endcase
         gap_pct  = (seg < 2) ? 9 : (seg < 4) ? 49 : 0;
         hold_pct = (seg < 2) ? 49 : (seg < 4) ? 9 : 0;
         send_pixel(Key565, PixW'($urandom));
         send_pixel(Key555, PixW'($urandom));
         send_pixel(16'hFFFF, 16'hFFFF);
         send_pixel((seg % 2) ? (Key555 | 16'h8000) : 16'h0000, 16'hFFFF);
         repeat (330) begin
            pick = $urandom_range(99);
            d = PixW'($urandom);
            if (pick < 8)
               s = ledger.fmt565 ? Key565 : Key555;
            else if (pick < 12)
               s = ledger.fmt565 ? Key555 : Key565;
            else
               s = PixW'($urandom);
            send_pixel(s, d);
         end
         drain_results();
      end
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ grayscale_tint_pixel_blend.f @@
rtl/gtpb_pkg.sv
rtl/gtpb_csr.sv
rtl/gtpb_gray.sv
rtl/gtpb_shade.sv
rtl/grayscale_tint_pixel_blend.sv
bench/tb_grayscale_tint_pixel_blend.sv
